[src/isct_pkg.sv]
// ----------------------------------------------------------------------------
// Incoming stream credit tracker package
// Shared codes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package isct_pkg;

  localparam int NUM_W    = 60;
  localparam int REASON_W = 32;
  localparam int CREDIT_W = 7;

  localparam logic [1:0] OP_OPEN    = 2'd0;
  localparam logic [1:0] OP_ACCEPT  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CLOSE   = 2'd3;

  // Frame type that carries a limit update.
  localparam logic [7:0] FRAME_MAX_STREAMS = 8'h13;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ABOVE      = 3'd1,
    ST_CLOSED     = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TWICE      = 3'd4,
    ST_NOT_READY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_FILL
  } state_t;

  typedef struct packed {
    logic latch;
    logic look;
    logic exec;
    logic fill;
  } cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_last;
  } stat_t;

endpackage

[src/incoming_stream_credit_tracker_unit.sv]
// ----------------------------------------------------------------------------
// Incoming stream credit tracker
// Peer stream table under a stream-count credit, with an APB credit register.
// ----------------------------------------------------------------------------
// Sequence: start latches the request, then lookup and execute; the strobe is
// registered from execute, or from the last step of the fill loop for an opened
// range, which inserts one table entry a cycle. start is taken only in idle.
// Results cannot be stalled; a strobe lasts exactly one cycle.
// Reset (synchronous, rst_n low) empties the table, sets both counters to
// one and clears the credit, the limit and the close state.
module incoming_stream_credit_tracker_unit import isct_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [NUM_W-1:0]    in_stream_num,
  input  logic [REASON_W-1:0] in_close_reason,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic                out_stream_found,
  output logic [NUM_W-1:0]    out_stream_out,
  output logic                out_limit_update,
  output logic [NUM_W-1:0]    out_new_limit,
  output logic [REASON_W-1:0] out_reason_out,
  output logic                out_shutdown_all,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic REG_CREDIT = 1'b0;

  cmd_t                cmd;
  stat_t               stat;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CREDIT);

  assign credit_nxt = cfg_we ? pwdata[CREDIT_W-1:0] : credit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_CREDIT) ? {{(32 - CREDIT_W){1'b0}}, credit_r} : '0;

  isct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  isct_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_stream_num    (in_stream_num),
    .in_close_reason  (in_close_reason),
    .cfg_we           (cfg_we),
    .credit           (credit_nxt),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_stream_found (out_stream_found),
    .out_stream_out   (out_stream_out),
    .out_limit_update (out_limit_update),
    .out_new_limit    (out_new_limit),
    .out_reason_out   (out_reason_out),
    .out_shutdown_all (out_shutdown_all)
  );

endmodule

[src/isct_ctrl.sv]
// ----------------------------------------------------------------------------
// Incoming stream credit tracker controller
// Sequences latch, table lookup, execute and the range fill loop.
// ----------------------------------------------------------------------------
module isct_ctrl import isct_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_fill ? S_FILL : S_IDLE;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[src/isct_dp.sv]
// ----------------------------------------------------------------------------
// Incoming stream credit tracker datapath
// Stream table with parallel number compare, counters and result registers.
// ----------------------------------------------------------------------------
module isct_dp import isct_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [1:0]            in_op,
  input  logic [NUM_W-1:0]      in_stream_num,
  input  logic [REASON_W-1:0]   in_close_reason,
  input  logic                  cfg_we,
  input  logic [CREDIT_W-1:0]   credit,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic                  out_stream_found,
  output logic [NUM_W-1:0]      out_stream_out,
  output logic                  out_limit_update,
  output logic [NUM_W-1:0]      out_new_limit,
  output logic [REASON_W-1:0]   out_reason_out,
  output logic                  out_shutdown_all
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [NUM_W-1:0]       ent_num_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] live_r, live_nxt;
  logic [TABLE_DEPTH-1:0] pend_r, pend_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [NUM_W-1:0]       no_r, no_nxt, na_r, na_nxt, ha_r, ha_nxt;
  logic                   closed_r, closed_nxt;
  logic [REASON_W-1:0]    reason_r, reason_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [NUM_W-1:0]       num_r, num_nxt;
  logic [REASON_W-1:0]    rsn_r, rsn_nxt;
  logic                   hit_r, hit_nxt;
  logic [IW-1:0]          hidx_r, hidx_nxt;
  logic [NUM_W-1:0]       cur_r, cur_nxt;

  logic                   valid_r, valid_nxt;
  status_t                status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic [NUM_W-1:0]       sout_r, sout_nxt;
  logic                   lim_r, lim_nxt;
  logic [NUM_W-1:0]       nlim_r, nlim_nxt;
  logic                   shut_r, shut_nxt;

  logic [NUM_W-1:0]       key;
  logic                   hit;
  logic [IW-1:0]          hidx;
  logic [IW-1:0]          fidx;
  logic                   wr_en;
  logic [IW-1:0]          wr_idx;
  logic [NUM_W:0]         needed;
  logic [CW-1:0]          free_cnt;
  logic                   range_ok;
  logic                   do_rel;
  logic                   rel_report;
  logic [NUM_W-1:0]       rel_n, rel_na;
  logic [CW-1:0]          cnt_dec;

  // Parallel compare against all live entries; lowest index wins.
  assign key = cmd.fill ? cur_r : ((op_r == OP_ACCEPT) ? na_r : num_r);

  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    fidx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (live_r[i] && ent_num_r[i] == key) begin
        hit  = 1'b1;
        hidx = IW'(i);
      end
      if (!live_r[i]) begin
        fidx = IW'(i);
      end
    end
  end

  assign needed   = {1'b0, num_r} - {1'b0, no_r} + {{NUM_W{1'b0}}, 1'b1};
  assign free_cnt = DEPTH_C - cnt_r;
  assign range_ok = (num_r <= ha_r) && (num_r >= no_r) &&
                    (needed <= (NUM_W + 1)'(free_cnt));

  assign stat.need_fill = (op_r == OP_OPEN) && range_ok;
  assign stat.fill_last = (cur_r == num_r);

  always_comb begin
    live_nxt   = live_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    no_nxt     = no_r;
    na_nxt     = na_r;
    ha_nxt     = ha_r;
    closed_nxt = closed_r;
    reason_nxt = reason_r;
    op_nxt     = op_r;
    num_nxt    = num_r;
    rsn_nxt    = rsn_r;
    hit_nxt    = hit_r;
    hidx_nxt   = hidx_r;
    cur_nxt    = cur_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    found_nxt  = found_r;
    sout_nxt   = sout_r;
    lim_nxt    = lim_r;
    nlim_nxt   = nlim_r;
    shut_nxt   = shut_r;
    wr_en      = 1'b0;
    wr_idx     = fidx;
    do_rel     = 1'b0;
    rel_report = 1'b0;
    rel_n      = num_r;
    rel_na     = na_r;
    cnt_dec    = (cnt_r != '0) ? cnt_r - CW'(1) : cnt_r;

    if (cmd.latch) begin
      op_nxt  = in_op;
      num_nxt = in_stream_num;
      rsn_nxt = in_close_reason;
    end

    if (cmd.look) begin
      hit_nxt  = hit;
      hidx_nxt = hidx;
    end

    if (cmd.exec) begin
      status_nxt = ST_OK;
      found_nxt  = 1'b0;
      sout_nxt   = '0;
      lim_nxt    = 1'b0;
      nlim_nxt   = '0;
      shut_nxt   = 1'b0;
      valid_nxt  = !stat.need_fill;
      case (op_r)
        OP_OPEN: begin
          if (num_r > ha_r) begin
            status_nxt = ST_ABOVE;
          end else if (num_r < no_r) begin
            if (hit_r && !pend_r[hidx_r]) begin
              found_nxt = 1'b1;
              sout_nxt  = num_r;
            end
          end else if (!range_ok) begin
            status_nxt = ST_ABOVE;
          end else begin
            found_nxt = 1'b1;
            sout_nxt  = num_r;
            cur_nxt   = no_r;
          end
        end
        OP_ACCEPT: begin
          if (closed_r) begin
            status_nxt = ST_CLOSED;
          end else if (!hit_r) begin
            status_nxt = ST_NOT_READY;
          end else begin
            na_nxt    = na_r + NUM_W'(1);
            found_nxt = 1'b1;
            sout_nxt  = na_r;
            do_rel    = pend_r[hidx_r];
            rel_n     = na_r;
            rel_na    = na_r + NUM_W'(1);
          end
        end
        OP_RELEASE: begin
          if (!hit_r) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            do_rel     = 1'b1;
            rel_report = 1'b1;
          end
        end
        OP_CLOSE: begin
          closed_nxt = 1'b1;
          reason_nxt = rsn_r;
          shut_nxt   = 1'b1;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase

      if (do_rel) begin
        if (rel_n >= rel_na) begin
          // Not yet accepted: only mark it, the accept finishes the job.
          if (pend_r[hidx_r]) begin
            if (rel_report) begin
              status_nxt = ST_TWICE;
            end
          end else begin
            pend_nxt[hidx_r] = 1'b1;
          end
        end else begin
          live_nxt[hidx_r] = 1'b0;
          pend_nxt[hidx_r] = 1'b0;
          cnt_nxt          = cnt_dec;
          if (32'(credit) > 32'(cnt_dec)) begin
            ha_nxt   = no_r + NUM_W'(credit) - NUM_W'(cnt_dec) - NUM_W'(1);
            lim_nxt  = 1'b1;
            nlim_nxt = ha_nxt;
          end
        end
      end
    end

    if (cmd.fill) begin
      if (hit) begin
        pend_nxt[hidx] = 1'b0;
      end else begin
        live_nxt[fidx] = 1'b1;
        pend_nxt[fidx] = 1'b0;
        wr_en          = 1'b1;
        cnt_nxt        = cnt_r + CW'(1);
      end
      if (stat.fill_last) begin
        no_nxt    = num_r + NUM_W'(1);
        valid_nxt = 1'b1;
      end else begin
        cur_nxt = cur_r + NUM_W'(1);
      end
    end

    if (cfg_we) begin
      ha_nxt = NUM_W'(credit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      pend_r   <= '0;
      cnt_r    <= '0;
      no_r     <= NUM_W'(1);
      na_r     <= NUM_W'(1);
      ha_r     <= '0;
      closed_r <= 1'b0;
      reason_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      live_r   <= live_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      no_r     <= no_nxt;
      na_r     <= na_nxt;
      ha_r     <= ha_nxt;
      closed_r <= closed_nxt;
      reason_r <= reason_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    num_r    <= num_nxt;
    rsn_r    <= rsn_nxt;
    hit_r    <= hit_nxt;
    hidx_r   <= hidx_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    sout_r   <= sout_nxt;
    lim_r    <= lim_nxt;
    nlim_r   <= nlim_nxt;
    shut_r   <= shut_nxt;
    if (wr_en) begin
      ent_num_r[wr_idx] <= cur_r;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_stream_found = found_r;
  assign out_stream_out   = sout_r;
  assign out_limit_update = lim_r;
  assign out_new_limit    = nlim_r;
  assign out_reason_out   = reason_r;
  assign out_shutdown_all = shut_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(live_r))
    else $error("live count differs from live entries");

  a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~live_r) == '0)
    else $error("pending release on a free entry");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe held for two cycles");

endmodule
